@@ rtl/kepler_true_anomaly_solver_unit_macros.svh @@
// Assertion macros used by the solver unit.
`ifndef KEPLER_TRUE_ANOMALY_SOLVER_UNIT_MACROS_SVH
`define KEPLER_TRUE_ANOMALY_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KTAS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ktas check failed");
// next-cycle implication
`define KTAS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ktas check failed");
`else
`define KTAS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KTAS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ktas_pkg.sv @@
`default_nettype none
package ktas_pkg;

   // datapath width of the CORDIC registers
   localparam int CW = 36;
   localparam int CORDIC_STEPS = 30;

   localparam logic signed [CW-1:0] Q30_ONE     = 36'sd1073741824;
   localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic [31:0]          STEP_CAP    = 32'h8000_0000;

   typedef struct packed {
      logic signed [30:0] mean_anomaly;
      logic [29:0]        eccentricity;
   } req_type;

   typedef struct packed {
      logic signed [30:0] eccentric_anomaly;
      logic signed [31:0] true_anomaly;
      logic               converged;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   // arctangent table, Q.30
   function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [CW-1:0] a;
      case (idx)
         5'd0:  a = 36'sd843314857;
         5'd1:  a = 36'sd497837829;
         5'd2:  a = 36'sd263043837;
         5'd3:  a = 36'sd133525159;
         5'd4:  a = 36'sd67021687;
         5'd5:  a = 36'sd33543516;
         5'd6:  a = 36'sd16775851;
         5'd7:  a = 36'sd8388437;
         5'd8:  a = 36'sd4194283;
         5'd9:  a = 36'sd2097149;
         5'd10: a = 36'sd1048576;
         5'd11: a = 36'sd524288;
         5'd12: a = 36'sd262144;
         5'd13: a = 36'sd131072;
         5'd14: a = 36'sd65536;
         5'd15: a = 36'sd32768;
         5'd16: a = 36'sd16384;
         5'd17: a = 36'sd8192;
         5'd18: a = 36'sd4096;
         5'd19: a = 36'sd2048;
         5'd20: a = 36'sd1024;
         5'd21: a = 36'sd512;
         5'd22: a = 36'sd256;
         5'd23: a = 36'sd128;
         5'd24: a = 36'sd64;
         5'd25: a = 36'sd32;
         5'd26: a = 36'sd16;
         5'd27: a = 36'sd8;
         5'd28: a = 36'sd4;
         5'd29: a = 36'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

@@ rtl/kepler_true_anomaly_solver_unit.sv @@
`default_nettype none
// Kepler equation solver: mean anomaly and eccentricity in, eccentric
// anomaly, true anomaly and a converged flag out.
// Request channel req_*: valid/ready, one request holds M (Q3.28) and e (Q0.30).
// Response channel rsp_*: valid/ready, one response per request.
// CSR port csr_*: max_iterations at 0x0, step_tolerance at 0x4; write only
// while the unit is idle.
// One request at a time. Each Newton step runs the CORDIC sin/cos, the two
// multiplies with the divide start, and the serial divide. The tail runs the
// sin/cos, e*e and setup, a 32-step square root, the beta divide, two
// multiplies and the CORDIC arctangent; rsp_valid rises when the tail is done.
// The divider and the CORDIC unit are shared by the Newton steps and the tail.
// req_ready is high only when no request is in flight. The response is held
// in a register until rsp_ready takes it; the next request is accepted after.
// Reset is synchronous; it returns the unit to idle and loads the CSR defaults
// (max_iterations 10, step_tolerance 1). No clearing pass is needed.
module kepler_true_anomaly_solver_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ktas_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ktas_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import ktas_pkg::*;

`include "kepler_true_anomaly_solver_unit_macros.svh"

   typedef enum logic [4:0] {
      ST_IDLE, ST_ROT, ST_ROT_WAIT, ST_MUL_S, ST_MUL_C, ST_DEN, ST_DIV_WAIT,
      ST_MUL_E2, ST_SQRT_INIT, ST_SQRT, ST_BETA, ST_BETA_WAIT, ST_MUL_BS,
      ST_MUL_BC, ST_VEC, ST_VEC_WAIT, ST_OUT
   } state_type;

   localparam logic CSR_MAX_ITER = 1'b0;
   localparam logic CSR_STEP_TOL = 1'b1;

   state_type          state_ff, state_in;
   logic [3:0]         max_iter_ff, max_iter_in;
   logic [15:0]        tol_ff, tol_in;
   logic signed [30:0] m_ff, m_in, ea_ff, ea_in;
   logic [29:0]        ecc_ff, ecc_in, beta_ff, beta_in;
   logic [3:0]         limit_ff, limit_in, iter_ff, iter_in;
   logic               conv_ff, conv_in, final_ff, final_in, neg_ff, neg_in;
   logic signed [31:0] sn_ff, sn_in, cs_ff, cs_in, ny_ff, ny_in;
   logic signed [62:0] prod_ff, prod_in;
   logic signed [33:0] num_ff, num_in;
   logic [63:0]        sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [4:0]         sq_cnt_ff, sq_cnt_in;
   rsp_type            rsp_ff, rsp_in;

   // shared unit hookup
   cordic_cmd_type     cor_cmd;
   logic signed [CW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
   logic               cor_done;
   logic               div_start, div_done, div_ovf;
   logic [63:0]        div_dividend;
   logic [31:0]        div_divisor;
   logic [32:0]        div_quot;

   // combinational helpers
   logic               csr_wr;
   logic signed [CW-1:0] ang, zred, ys, xs;
   logic               zneg;
   logic signed [30:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] prod_ext, rnd32, rnd30;
   logic signed [33:0] den_full, nx_full, mag_s, ea_upd;
   logic [33:0]        mag;
   logic [31:0]        q;
   logic [63:0]        sq_sum;
   logic signed [37:0] twice_z, tr_full;

   ktas_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cor_cmd),
      .x_init (cor_x0),
      .y_init (cor_y0),
      .z_init (cor_z0),
      .done   (cor_done),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z)
   );

   ktas_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot),
      .overflow (div_ovf)
   );

   // CSR access
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_STEP_TOL) ? {16'b0, tol_ff}
                                                      : {28'b0, max_iter_ff};

   // angle reduction into [-pi/2, pi/2] for sin/cos
   always_comb begin
      ang  = CW'($signed({ea_ff, 2'b00}));
      zred = ang;
      zneg = 1'b0;
      if (ang > Q30_HALF_PI) begin
         zred = ang - Q30_PI;
         zneg = 1'b1;
      end else if (ang < -Q30_HALF_PI) begin
         zred = ang + Q30_PI;
         zneg = 1'b1;
      end
   end

   // sin/cos sign fix and clamp to [-1, 1]
   always_comb begin
      ys = neg_ff ? -cor_y : cor_y;
      xs = neg_ff ? -cor_x : cor_x;
      if (ys > Q30_ONE)       ys = Q30_ONE;
      else if (ys < -Q30_ONE) ys = -Q30_ONE;
      if (xs > Q30_ONE)       xs = Q30_ONE;
      else if (xs < -Q30_ONE) xs = -Q30_ONE;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = $signed({1'b0, ecc_ff});
      mul_b = sn_ff;
      case (state_ff)
         ST_MUL_C:  mul_b = cs_ff;
         ST_MUL_E2: mul_b = $signed({2'b00, ecc_ff});
         ST_MUL_BS: mul_a = $signed({1'b0, beta_ff});
         ST_MUL_BC: begin
            mul_a = $signed({1'b0, beta_ff});
            mul_b = cs_ff;
         end
         default: mul_b = sn_ff;
      endcase
      prod_in = 63'(mul_a * mul_b);
   end

   // product rounding, Newton numerator, denominator and update, true anomaly
   always_comb begin
      prod_ext = 64'(prod_ff);
      rnd32    = (prod_ext + 64'sd2147483648) >>> 32;
      rnd30    = (prod_ext + 64'sd536870912) >>> 30;
      num_in   = 34'(ea_ff) - rnd32[33:0] - 34'(m_ff);
      den_full = 34'sd1073741824 - rnd30[33:0];
      if (den_full < 34'sd1) den_full = 34'sd1;
      nx_full  = den_full;
      mag_s    = num_ff[33] ? -num_ff : num_ff;
      mag      = mag_s;
      q        = (div_ovf || div_quot > {1'b0, STEP_CAP}) ? STEP_CAP : div_quot[31:0];
      ea_upd   = num_ff[33] ? 34'(ea_ff) + $signed({2'b00, q})
                            : 34'(ea_ff) - $signed({2'b00, q});
      if (ea_upd > 34'sd1073741823)       ea_upd = 34'sd1073741823;
      else if (ea_upd < -34'sd1073741824) ea_upd = -34'sd1073741824;
      sq_sum   = sq_res_ff + sq_bit_ff;
      twice_z  = 38'(cor_z) <<< 1;
      tr_full  = 38'(ea_ff) + ((twice_z + 38'sd2) >>> 2);
      if (tr_full > 38'sd2147483647)       tr_full = 38'sd2147483647;
      else if (tr_full < -38'sd2147483648) tr_full = -38'sd2147483648;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      max_iter_in = max_iter_ff;
      tol_in      = tol_ff;
      m_in        = m_ff;
      ecc_in      = ecc_ff;
      ea_in       = ea_ff;
      beta_in     = beta_ff;
      limit_in    = limit_ff;
      iter_in     = iter_ff;
      conv_in     = conv_ff;
      final_in    = final_ff;
      neg_in      = neg_ff;
      sn_in       = sn_ff;
      cs_in       = cs_ff;
      ny_in       = ny_ff;
      sq_v_in     = sq_v_ff;
      sq_res_in   = sq_res_ff;
      sq_bit_in   = sq_bit_ff;
      sq_cnt_in   = sq_cnt_ff;
      rsp_in      = rsp_ff;
      cor_cmd     = '0;
      cor_x0      = CORDIC_GAIN;
      cor_y0      = '0;
      cor_z0      = zred;
      div_start   = 1'b0;
      div_dividend = {mag, 30'b0};
      div_divisor  = den_full[31:0];

      if (csr_wr) begin
         if (csr_paddr[2] == CSR_MAX_ITER) max_iter_in = csr_pwdata[3:0];
         else                              tol_in      = csr_pwdata[15:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in     = req_data.mean_anomaly;
               ea_in    = req_data.mean_anomaly;
               ecc_in   = req_data.eccentricity;
               limit_in = max_iter_ff;
               iter_in  = '0;
               conv_in  = 1'b0;
               final_in = (max_iter_ff == 4'd0);
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cor_cmd.start = 1'b1;
            neg_in        = zneg;
            state_in      = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (cor_done) begin
               sn_in    = ys[31:0];
               cs_in    = xs[31:0];
               state_in = final_ff ? ST_MUL_E2 : ST_MUL_S;
            end
         end
         ST_MUL_S: state_in = ST_MUL_C;
         ST_MUL_C: state_in = ST_DEN;
         ST_DEN: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               ea_in    = ea_upd[30:0];
               iter_in  = iter_ff + 4'd1;
               state_in = ST_ROT;
               if (q < {16'b0, tol_ff}) begin
                  conv_in  = 1'b1;
                  final_in = 1'b1;
               end else if (iter_ff + 4'd1 == limit_ff) begin
                  final_in = 1'b1;
               end
            end
         end
         ST_MUL_E2: state_in = ST_SQRT_INIT;
         ST_SQRT_INIT: begin
            sq_v_in   = 64'(34'sd1073741824 - rnd30[33:0]) << 30;
            sq_res_in = '0;
            sq_bit_in = 64'h4000_0000_0000_0000;
            sq_cnt_in = '0;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            // one result bit per cycle
            if (sq_v_ff >= sq_sum) begin
               sq_v_in   = sq_v_ff - sq_sum;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 5'd1;
            if (sq_cnt_ff == 5'd31) state_in = ST_BETA;
         end
         ST_BETA: begin
            div_start    = 1'b1;
            div_dividend = {4'b0, ecc_ff, 30'b0};
            div_divisor  = 32'd1073741824 + sq_res_ff[31:0];
            state_in     = ST_BETA_WAIT;
         end
         ST_BETA_WAIT: begin
            if (div_done) begin
               beta_in  = div_quot[29:0];
               state_in = ST_MUL_BS;
            end
         end
         ST_MUL_BS: state_in = ST_MUL_BC;
         ST_MUL_BC: begin
            ny_in    = rnd30[31:0];
            state_in = ST_VEC;
         end
         ST_VEC: begin
            cor_cmd.start     = 1'b1;
            cor_cmd.vectoring = 1'b1;
            cor_x0            = CW'(nx_full);
            cor_y0            = CW'(ny_ff);
            cor_z0            = '0;
            state_in          = ST_VEC_WAIT;
         end
         ST_VEC_WAIT: begin
            if (cor_done) begin
               rsp_in.eccentric_anomaly = ea_ff;
               rsp_in.true_anomaly      = tr_full[31:0];
               rsp_in.converged         = conv_ff;
               state_in                 = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         max_iter_ff <= 4'd10;
         tol_ff      <= 16'd1;
         limit_ff    <= '0;
         iter_ff     <= '0;
         conv_ff     <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         max_iter_ff <= max_iter_in;
         tol_ff      <= tol_in;
         limit_ff    <= limit_in;
         iter_ff     <= iter_in;
         conv_ff     <= conv_in;
         final_ff    <= final_in;
      end
      m_ff      <= m_in;
      ecc_ff    <= ecc_in;
      ea_ff     <= ea_in;
      beta_ff   <= beta_in;
      neg_ff    <= neg_in;
      sn_ff     <= sn_in;
      cs_ff     <= cs_in;
      ny_ff     <= ny_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   // checks
   `KTAS_ASSERT_IMP(a_idle_excl, clock, reset, req_ready, !rsp_valid)
   `KTAS_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `KTAS_ASSERT_IMP(a_iter_bound, clock, reset, 1'b1, iter_ff <= limit_ff)
   `KTAS_ASSERT_IMP(a_conv_needs_step, clock, reset, rsp_valid && rsp_data.converged, limit_ff != 4'd0)

endmodule
`default_nettype wire

@@ rtl/ktas_cordic.sv @@
`default_nettype none
// Iterative CORDIC: one micro-rotation per cycle, rotation or vectoring mode.
module ktas_cordic (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ktas_pkg::cordic_cmd_type       cmd,
   input  wire logic signed [ktas_pkg::CW-1:0] x_init,
   input  wire logic signed [ktas_pkg::CW-1:0] y_init,
   input  wire logic signed [ktas_pkg::CW-1:0] z_init,
   output logic                                done,
   output logic signed [ktas_pkg::CW-1:0]      x_out,
   output logic signed [ktas_pkg::CW-1:0]      y_out,
   output logic signed [ktas_pkg::CW-1:0]      z_out
);
   import ktas_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 vec_ff, vec_in;
   logic [4:0]           idx_ff, idx_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CW-1:0] dx, dy, ang;
   logic                 dir_down;

   // one micro-rotation
   always_comb begin
      dx       = y_ff >>> idx_ff;
      dy       = x_ff >>> idx_ff;
      ang      = atan_entry(idx_ff);
      dir_down = vec_ff ? !(y_ff > 0) : (z_ff >= 0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      vec_in   = vec_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         vec_in  = cmd.vectoring;
         idx_in  = '0;
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
      end else if (busy_ff) begin
         if (dir_down) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         idx_in = idx_ff + 5'd1;
         if (idx_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      vec_ff <= vec_in;
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule
`default_nettype wire

@@ rtl/ktas_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Keeps the low 33 quotient bits and flags any higher bit.
module ktas_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [32:0]      quotient,
   output logic             overflow
);
   import ktas_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic        ovf_ff, ovf_in;
   logic [32:0] trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[63]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         ovf_in = ovf_ff | quo_ff[32];
         // remainder stays below the divisor, so 32 bits hold it
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule
`default_nettype wire
